FILE: design/nearest_profile_search_defines.svh
// ----------------------------------------------------------------------------
// nearest_profile_search_defines
// assertion macros for the profile search block
// ----------------------------------------------------------------------------
`ifndef NEAREST_PROFILE_SEARCH_DEFINES_SVH
`define NEAREST_PROFILE_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NPS_ASSERT_SAME(lbl, ante, cons, msg)
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// shared constants and distance functions for the profile search block
// ----------------------------------------------------------------------------
package nps_pkg;
  localparam int SCORE_W      = 7;
  localparam int SCORE_COUNT  = 6;
  localparam int ENTRY_W      = SCORE_W * SCORE_COUNT;
  localparam int IDX_W        = 6;
  localparam int DIST_W       = 16;
  localparam int KEY_W        = DIST_W + IDX_W;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam logic [SCORE_W-1:0] SCORE_LIMIT = 7'd100;

  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_COMPARE = 2'd1;
  localparam logic [1:0] CMD_NEAREST = 2'd2;
  localparam logic [1:0] CMD_RANK    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  function automatic logic [SCORE_W-1:0] abs_diff(input logic [SCORE_W-1:0] x,
                                                   input logic [SCORE_W-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [DIST_W-1:0] sq_dist(input logic [ENTRY_W-1:0] p,
                                                 input logic [ENTRY_W-1:0] q);
    logic [SCORE_W-1:0] d;
    logic [DIST_W-1:0]  acc;
    acc = '0;
    for (int k = 0; k < SCORE_COUNT; k++) begin
      d   = abs_diff(p[k*SCORE_W +: SCORE_W], q[k*SCORE_W +: SCORE_W]);
      acc = acc + DIST_W'(d) * DIST_W'(d);
    end
    return acc;
  endfunction
endpackage

FILE: design/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/nearest_profile_search.sv
// ----------------------------------------------------------------------------
// nearest_profile_search
// table of six-score profiles with compare, nearest and ranked search
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low.
// Append and rejected commands give one result on the cycle after the
// transaction; busy stays low for them.
// Compare reads the first entry in S_REF and the second in S_CMP, and
// registers its result from S_CMP.
// Nearest walks all n stored entries through the distance unit, one entry
// a cycle, and gives its result at the end of that pass.
// Ranked list makes n - 1 passes over all n entries of the table, and gives
// one result at the end of each pass, smallest key first; the last result
// carries out_last_result.
// The profile table is a ram with one write port and one registered read
// port; its read port sets the rate of one entry a cycle.
// Each result is held on the out_ ports for one cycle with out_valid high;
// the receiver takes it then and cannot stall.
// Reset clears the entry count and the sequencer; table contents are kept.
// ----------------------------------------------------------------------------
`include "nearest_profile_search_defines.svh"

module nearest_profile_search #(
  parameter int MAX_ENTRIES = nps_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [nps_pkg::IDX_W-1:0]    in_first_index,
  input  logic [nps_pkg::IDX_W-1:0]    in_second_index,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_a,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_b,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_c,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_d,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_e,
  input  logic [nps_pkg::SCORE_W-1:0]  in_score_f,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [nps_pkg::IDX_W-1:0]    out_partner_index,
  output logic [nps_pkg::DIST_W-1:0]   out_squared_distance,
  output logic [nps_pkg::SCORE_W-1:0]  out_smallest_difference,
  output logic [nps_pkg::SCORE_COUNT-1:0] out_closest_mask,
  output logic                         out_last_result
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = nps_pkg::SCORE_W;
  localparam int SN = nps_pkg::SCORE_COUNT;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REF  = 4'b0010,
    S_CMP  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [AW-1:0] ref_idx_r, ref_idx_nxt;
  logic [AW-1:0] sec_idx_r, sec_idx_nxt;
  logic [AW-1:0] scan_i_r, scan_i_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic [nps_pkg::ENTRY_W-1:0] ref_r, ref_nxt;
  logic [nps_pkg::KEY_W-1:0] prev_r, prev_nxt, best_r, best_nxt;
  logic          have_prev_r, have_prev_nxt, best_ok_r, best_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [nps_pkg::IDX_W-1:0]   out_partner_r, out_partner_nxt;
  logic [nps_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [SW-1:0] out_small_r, out_small_nxt;
  logic [SN-1:0] out_mask_r, out_mask_nxt;
  logic          out_last_r, out_last_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [nps_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [nps_pkg::DIST_W-1:0]  cand_dist;
  logic [nps_pkg::KEY_W-1:0]   cand_key, pick_key;
  logic                        cand_ok, take, pass_end, bad_score, idx_err;
  logic [SW-1:0]               diffs [SN];
  logic [SW-1:0]               least;

  nps_ram #(.WIDTH(nps_pkg::ENTRY_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {in_score_f, in_score_e, in_score_d, in_score_c, in_score_b, in_score_a};
  assign bad_score = (in_score_a > nps_pkg::SCORE_LIMIT) || (in_score_b > nps_pkg::SCORE_LIMIT)
                  || (in_score_c > nps_pkg::SCORE_LIMIT) || (in_score_d > nps_pkg::SCORE_LIMIT)
                  || (in_score_e > nps_pkg::SCORE_LIMIT) || (in_score_f > nps_pkg::SCORE_LIMIT);
  assign idx_err = (count_r < CW'(2))
                || ({1'b0, in_first_index} >= (nps_pkg::IDX_W+1)'(count_r))
                || ((in_command == nps_pkg::CMD_COMPARE)
                    && ({1'b0, in_second_index} >= (nps_pkg::IDX_W+1)'(count_r)));

  // shared distance unit
  assign cand_dist = nps_pkg::sq_dist(ref_r, ram_rdata);
  assign cand_key  = {cand_dist, nps_pkg::IDX_W'(scan_i_r)};
  assign cand_ok   = (scan_i_r != ref_idx_r) && (!have_prev_r || (cand_key > prev_r));
  assign take      = cand_ok && (!best_ok_r || (cand_key < best_r));
  assign pick_key  = take ? cand_key : best_r;
  assign pass_end  = (CW'(scan_i_r) == count_r - CW'(1));

  always_comb begin
    least = '1;
    for (int k = 0; k < SN; k++) begin
      diffs[k] = nps_pkg::abs_diff(ref_r[k*SW +: SW], ram_rdata[k*SW +: SW]);
      if (diffs[k] < least) begin
        least = diffs[k];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    ref_idx_nxt   = ref_idx_r;
    sec_idx_nxt   = sec_idx_r;
    scan_i_nxt    = scan_i_r;
    emitted_nxt   = emitted_r;
    ref_nxt       = ref_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    best_nxt      = best_r;
    best_ok_nxt   = best_ok_r;
    ram_we        = 1'b0;
    ram_raddr     = in_first_index[AW-1:0];
    out_valid_nxt   = 1'b0;
    out_status_nxt  = nps_pkg::ST_OK;
    out_partner_nxt = '0;
    out_dist_nxt    = '0;
    out_small_nxt   = '0;
    out_mask_nxt    = '0;
    out_last_nxt    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_command;
          ref_idx_nxt = in_first_index[AW-1:0];
          sec_idx_nxt = in_second_index[AW-1:0];
          if (in_command == nps_pkg::CMD_APPEND) begin
            out_valid_nxt = 1'b1;
            if (count_r >= CW'(MAX_ENTRIES)) begin
              out_status_nxt = nps_pkg::ST_FULL;
            end else if (bad_score) begin
              out_status_nxt = nps_pkg::ST_RANGE;
            end else begin
              ram_we          = 1'b1;
              out_partner_nxt = nps_pkg::IDX_W'(count_r);
              count_nxt       = count_r + CW'(1);
            end
          end else if (idx_err) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = nps_pkg::ST_INDEX;
          end else begin
            state_nxt = S_REF;
          end
        end
      end
      S_REF: begin
        ref_nxt       = ram_rdata;
        emitted_nxt   = '0;
        have_prev_nxt = 1'b0;
        best_ok_nxt   = 1'b0;
        scan_i_nxt    = '0;
        if (cmd_r == nps_pkg::CMD_COMPARE) begin
          ram_raddr = sec_idx_r;
          state_nxt = S_CMP;
        end else begin
          ram_raddr = '0;
          state_nxt = S_SCAN;
        end
      end
      S_CMP: begin
        out_valid_nxt   = 1'b1;
        out_partner_nxt = nps_pkg::IDX_W'(sec_idx_r);
        out_dist_nxt    = cand_dist;
        out_small_nxt   = least;
        for (int k = 0; k < SN; k++) begin
          out_mask_nxt[k] = (diffs[k] == least);
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        ram_raddr   = scan_i_r + AW'(1);
        scan_i_nxt  = scan_i_r + AW'(1);
        best_nxt    = pick_key;
        best_ok_nxt = best_ok_r || take;
        if (pass_end) begin
          out_valid_nxt   = 1'b1;
          out_partner_nxt = pick_key[nps_pkg::IDX_W-1:0];
          out_dist_nxt    = pick_key[nps_pkg::KEY_W-1:nps_pkg::IDX_W];
          out_last_nxt    = (cmd_r == nps_pkg::CMD_NEAREST)
                         || (emitted_r + CW'(2) == count_r);
          ram_raddr     = '0;
          scan_i_nxt    = '0;
          best_ok_nxt   = 1'b0;
          prev_nxt      = pick_key;
          have_prev_nxt = 1'b1;
          emitted_nxt   = emitted_r + CW'(1);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    ref_idx_r     <= ref_idx_nxt;
    sec_idx_r     <= sec_idx_nxt;
    scan_i_r      <= scan_i_nxt;
    emitted_r     <= emitted_nxt;
    ref_r         <= ref_nxt;
    prev_r        <= prev_nxt;
    have_prev_r   <= have_prev_nxt;
    best_r        <= best_nxt;
    best_ok_r     <= best_ok_nxt;
    out_status_r  <= out_status_nxt;
    out_partner_r <= out_partner_nxt;
    out_dist_r    <= out_dist_nxt;
    out_small_r   <= out_small_nxt;
    out_mask_r    <= out_mask_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_partner_index       = out_partner_r;
  assign out_squared_distance    = out_dist_r;
  assign out_smallest_difference = out_small_r;
  assign out_closest_mask        = out_mask_r;
  assign out_last_result         = out_last_r;

  `NPS_ASSERT_SAME(a_partial_only_in_rank, out_valid && !out_last_result, state_r == S_SCAN && cmd_r == nps_pkg::CMD_RANK, "non-final result outside ranking")
  `NPS_ASSERT_NEXT(a_start_answered, start && !busy, out_valid || busy, "transaction neither answered nor in progress")
  `NPS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES), "entry count above table depth")
endmodule
